### rtl/core/rect_pkg.sv
package rect_pkg;

    localparam int MaxWidth   = 256;
    localparam int MaxHeight  = 256;
    localparam int ColBits    = $clog2(MaxWidth);
    localparam int RowBits    = $clog2(MaxHeight);
    localparam int AddrBits   = ColBits + RowBits;
    localparam int RingCount  = 48;
    localparam int RingBits   = $clog2(RingCount);
    localparam logic [16:0] CountMax = 17'h1FFFF;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLOUR = 2'd2;
    localparam logic [1:0] REG_MINAREA = 2'd3;

    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    localparam logic [1:0] EDGE_NONE    = 2'd0;
    localparam logic [1:0] EDGE_FRESH   = 2'd1;
    localparam logic [1:0] EDGE_VISITED = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [7:0]  pixel_row;
        logic [7:0]  pixel_col;
        logic [31:0] pixel_value;
    } request_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [16:0] point_count;
    } result_t;

    typedef struct packed {
        logic                wr_en;
        logic [AddrBits-1:0] wr_addr;
        logic [1:0]          wr_data;
        logic [AddrBits-1:0] rd_addr;
    } edge_port_t;

    function automatic logic signed [2:0] ring_dx(input logic [RingBits-1:0] i);
        case (i)
            6'd0: ring_dx = -3'sd1; 6'd1: ring_dx = 3'sd0; 6'd2: ring_dx = 3'sd1;
            6'd3: ring_dx = 3'sd0; 6'd4: ring_dx = -3'sd1; 6'd5: ring_dx = 3'sd1;
            6'd6: ring_dx = 3'sd1; 6'd7: ring_dx = -3'sd1;
            6'd8: ring_dx = -3'sd2; 6'd9: ring_dx = -3'sd2; 6'd10: ring_dx = -3'sd2;
            6'd11: ring_dx = -3'sd1; 6'd12: ring_dx = 3'sd0; 6'd13: ring_dx = 3'sd1;
            6'd14: ring_dx = 3'sd2; 6'd15: ring_dx = 3'sd2; 6'd16: ring_dx = 3'sd2;
            6'd17: ring_dx = 3'sd2; 6'd18: ring_dx = 3'sd2; 6'd19: ring_dx = 3'sd1;
            6'd20: ring_dx = 3'sd0; 6'd21: ring_dx = -3'sd1; 6'd22: ring_dx = -3'sd2;
            6'd23: ring_dx = -3'sd2;
            6'd24: ring_dx = -3'sd3; 6'd25: ring_dx = -3'sd3; 6'd26: ring_dx = -3'sd3;
            6'd27: ring_dx = -3'sd3; 6'd28: ring_dx = -3'sd2; 6'd29: ring_dx = -3'sd1;
            6'd30: ring_dx = 3'sd0; 6'd31: ring_dx = 3'sd1; 6'd32: ring_dx = 3'sd2;
            6'd33: ring_dx = 3'sd3; 6'd34: ring_dx = 3'sd3; 6'd35: ring_dx = 3'sd3;
            6'd36: ring_dx = 3'sd3; 6'd37: ring_dx = 3'sd3; 6'd38: ring_dx = 3'sd3;
            6'd39: ring_dx = 3'sd3; 6'd40: ring_dx = 3'sd2; 6'd41: ring_dx = 3'sd1;
            6'd42: ring_dx = 3'sd0; 6'd43: ring_dx = -3'sd1; 6'd44: ring_dx = -3'sd2;
            6'd45: ring_dx = -3'sd3; 6'd46: ring_dx = -3'sd3; 6'd47: ring_dx = -3'sd3;
            default: ring_dx = 3'sd0;
        endcase
    endfunction

    function automatic logic signed [2:0] ring_dy(input logic [RingBits-1:0] i);
        case (i)
            6'd0: ring_dy = 3'sd0; 6'd1: ring_dy = 3'sd1; 6'd2: ring_dy = 3'sd0;
            6'd3: ring_dy = -3'sd1; 6'd4: ring_dy = 3'sd1; 6'd5: ring_dy = 3'sd1;
            6'd6: ring_dy = -3'sd1; 6'd7: ring_dy = -3'sd1;
            6'd8: ring_dy = 3'sd0; 6'd9: ring_dy = 3'sd1; 6'd10: ring_dy = 3'sd2;
            6'd11: ring_dy = 3'sd2; 6'd12: ring_dy = 3'sd2; 6'd13: ring_dy = 3'sd2;
            6'd14: ring_dy = 3'sd2; 6'd15: ring_dy = 3'sd1; 6'd16: ring_dy = 3'sd0;
            6'd17: ring_dy = -3'sd1; 6'd18: ring_dy = -3'sd2; 6'd19: ring_dy = -3'sd2;
            6'd20: ring_dy = -3'sd2; 6'd21: ring_dy = -3'sd2; 6'd22: ring_dy = -3'sd2;
            6'd23: ring_dy = -3'sd1;
            6'd24: ring_dy = 3'sd0; 6'd25: ring_dy = 3'sd1; 6'd26: ring_dy = 3'sd2;
            6'd27: ring_dy = 3'sd3; 6'd28: ring_dy = 3'sd3; 6'd29: ring_dy = 3'sd3;
            6'd30: ring_dy = 3'sd3; 6'd31: ring_dy = 3'sd3; 6'd32: ring_dy = 3'sd3;
            6'd33: ring_dy = 3'sd3; 6'd34: ring_dy = 3'sd2; 6'd35: ring_dy = 3'sd1;
            6'd36: ring_dy = 3'sd0; 6'd37: ring_dy = -3'sd1; 6'd38: ring_dy = -3'sd2;
            6'd39: ring_dy = -3'sd3; 6'd40: ring_dy = -3'sd3; 6'd41: ring_dy = -3'sd3;
            6'd42: ring_dy = -3'sd3; 6'd43: ring_dy = -3'sd3; 6'd44: ring_dy = -3'sd3;
            6'd45: ring_dy = -3'sd3; 6'd46: ring_dy = -3'sd2; 6'd47: ring_dy = -3'sd1;
            default: ring_dy = 3'sd0;
        endcase
    endfunction

endpackage

### rtl/core/region_edge_contour_tracer_top.sv
// A pixel load is written when it is accepted. A trace request runs in steps: the first
// request after a load or a width, height or colour write builds the edge map pixel by
// pixel, a contour start scans the edge map for a fresh edge, and a contour step probes
// up to 48 ring offsets. One request runs at a time; busy is high while a request runs.
// The edge-map memory and the pixel memory each have one read port.
// Reset clears control state; the memories are not cleared. Results cannot be stalled.
module region_edge_contour_tracer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rect_pkg::request_t request,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               result_valid,
    output rect_pkg::result_t  result
);
    import rect_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_BUILD_C, S_BUILD_L, S_BUILD_R, S_BUILD_U, S_BUILD_D, S_BUILD_W,
        S_SCAN_RD, S_SCAN_CHK, S_RING_RD, S_RING_CHK, S_END_MUL, S_END_FIN
    } state_t;

    state_t state_reg;
    logic [1:0]  phase_reg;
    logic [8:0]  width_reg, height_reg;
    logic [31:0] colour_reg;
    logic [15:0] min_area_reg;
    logic [7:0]  cur_row_reg, cur_col_reg, start_row_reg, start_col_reg;
    logic [7:0]  row_reg, col_reg;
    logic [RingBits-1:0] ring_reg;
    logic [16:0] count_reg;
    logic signed [39:0] area_reg;
    logic [31:0] ctr_reg, lv_reg, rv_reg, uv_reg;
    logic signed [17:0] prod_a_reg, prod_b_reg;

    logic [8:0] eff_w, eff_h;
    assign eff_w = (width_reg > 9'(MaxWidth)) ? 9'(MaxWidth) : width_reg;
    assign eff_h = (height_reg > 9'(MaxHeight)) ? 9'(MaxHeight) : height_reg;

    edge_port_t  eport;
    logic [1:0]  edge_rd;
    logic        pix_we;
    logic [AddrBits-1:0] pix_waddr, pix_raddr;
    logic [31:0] pix_rd;

    rect_edge_mem u_edge (.clk(clk), .port(eport), .rd_data(edge_rd));
    rect_pixel_mem u_pix (
        .clk(clk), .wr_en(pix_we), .wr_addr(pix_waddr), .wr_data(request.pixel_value),
        .rd_addr(pix_raddr), .rd_data(pix_rd)
    );

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Ring probe position.
    logic signed [9:0] probe_r, probe_c;
    logic probe_ok;
    assign probe_r = $signed({2'b0, cur_row_reg}) + 10'(ring_dy(ring_reg));
    assign probe_c = $signed({2'b0, cur_col_reg}) + 10'(ring_dx(ring_reg));
    assign probe_ok = (probe_r >= 0) && (probe_r < $signed({1'b0, eff_h}))
                   && (probe_c >= 0) && (probe_c < $signed({1'b0, eff_w}));

    logic last_col, last_row, border;
    assign last_col = ({1'b0, col_reg} == eff_w - 9'd1);
    assign last_row = ({1'b0, row_reg} == eff_h - 9'd1);
    assign border   = (row_reg == 8'd0) || (col_reg == 8'd0) || last_row || last_col;

    logic build_edge;
    assign build_edge = (ctr_reg == colour_reg) && (border
        || ((lv_reg != rv_reg) && ((lv_reg == colour_reg) || (rv_reg == colour_reg)))
        || ((uv_reg != pix_rd) && ((uv_reg == colour_reg) || (pix_rd == colour_reg))));

    logic signed [39:0] area_sum, area_abs;
    assign area_sum = area_reg + 40'(prod_a_reg) - 40'(prod_b_reg);
    assign area_abs = area_sum < 0 ? -area_sum : area_sum;

    logic [8:0] dr, dc;
    assign dr = (start_row_reg > cur_row_reg) ? 9'(start_row_reg - cur_row_reg)
                                              : 9'(cur_row_reg - start_row_reg);
    assign dc = (start_col_reg > cur_col_reg) ? 9'(start_col_reg - cur_col_reg)
                                              : 9'(cur_col_reg - start_col_reg);

    always_comb
    begin
        pix_we    = accept && !request.mode;
        pix_waddr = {request.pixel_row, request.pixel_col};
        pix_raddr = {row_reg, col_reg};
        case (state_reg)
            S_BUILD_L: pix_raddr = {row_reg, col_reg - 8'd1};
            S_BUILD_R: pix_raddr = {row_reg, col_reg + 8'd1};
            S_BUILD_U: pix_raddr = {row_reg + 8'd1, col_reg};
            S_BUILD_D: pix_raddr = {row_reg - 8'd1, col_reg};
            default:   pix_raddr = {row_reg, col_reg};
        endcase
        eport.wr_en   = 1'b0;
        eport.wr_addr = {row_reg, col_reg};
        eport.wr_data = EDGE_NONE;
        eport.rd_addr = {row_reg, col_reg};
        case (state_reg)
            S_BUILD_W:
            begin
                eport.wr_en   = 1'b1;
                eport.wr_data = build_edge ? EDGE_FRESH : EDGE_NONE;
            end
            S_SCAN_CHK:
            begin
                eport.wr_en   = (edge_rd == EDGE_FRESH);
                eport.wr_data = EDGE_VISITED;
            end
            S_RING_RD:
            begin
                eport.rd_addr = {probe_r[7:0], probe_c[7:0]};
            end
            S_RING_CHK:
            begin
                eport.wr_en   = (edge_rd == EDGE_FRESH);
                eport.wr_addr = {row_reg, col_reg};
                eport.wr_data = EDGE_VISITED;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 2'd0;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            colour_reg    <= 32'd255;
            min_area_reg  <= 16'd10;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            start_row_reg <= '0;
            start_col_reg <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            ring_reg      <= '0;
            count_reg     <= '0;
            area_reg      <= '0;
            result_valid  <= 1'b0;
            result        <= '0;
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WIDTH:   begin width_reg  <= cfg_data[8:0]; phase_reg <= 2'd0; end
                    REG_HEIGHT:  begin height_reg <= cfg_data[8:0]; phase_reg <= 2'd0; end
                    REG_COLOUR:  begin colour_reg <= cfg_data;      phase_reg <= 2'd0; end
                    REG_MINAREA: min_area_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        row_reg  <= '0;
                        col_reg  <= '0;
                        ring_reg <= '0;
                        if (!request.mode)
                        begin
                            phase_reg <= 2'd0;
                        end
                        else if (phase_reg == 2'd0)
                        begin
                            phase_reg <= 2'd1;
                            if (eff_w != 9'd0 && eff_h != 9'd0)
                            begin
                                state_reg <= S_BUILD_C;
                            end
                        end
                        else if (phase_reg == 2'd3)
                        begin
                            result_valid <= 1'b1;
                            result       <= '{KIND_DONE, 8'd0, 8'd0, 17'd0};
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            if (eff_w == 9'd0 || eff_h == 9'd0)
                            begin
                                phase_reg    <= 2'd3;
                                result_valid <= 1'b1;
                                result       <= '{KIND_DONE, 8'd0, 8'd0, 17'd0};
                            end
                            else
                            begin
                                state_reg <= S_SCAN_RD;
                            end
                        end
                        else
                        begin
                            state_reg <= S_RING_RD;
                        end
                    end
                end
                S_BUILD_C:
                begin
                    state_reg <= S_BUILD_L;
                end
                S_BUILD_L:
                begin
                    ctr_reg   <= pix_rd;
                    state_reg <= S_BUILD_R;
                end
                S_BUILD_R:
                begin
                    lv_reg    <= pix_rd;
                    state_reg <= S_BUILD_U;
                end
                S_BUILD_U:
                begin
                    rv_reg    <= pix_rd;
                    state_reg <= S_BUILD_D;
                end
                S_BUILD_D:
                begin
                    uv_reg    <= pix_rd;
                    state_reg <= S_BUILD_W;
                end
                S_BUILD_W:
                begin
                    state_reg <= S_BUILD_C;
                    if ({1'b0, col_reg} == eff_w - 9'd1)
                    begin
                        col_reg <= '0;
                        if ({1'b0, row_reg} == eff_h - 9'd1)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            row_reg <= row_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 8'd1;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    state_reg <= S_SCAN_RD;
                    if (edge_rd == EDGE_FRESH)
                    begin
                        start_row_reg <= row_reg;
                        cur_row_reg   <= row_reg;
                        start_col_reg <= col_reg;
                        cur_col_reg   <= col_reg;
                        count_reg     <= 17'd1;
                        area_reg      <= '0;
                        phase_reg     <= 2'd2;
                        state_reg     <= S_IDLE;
                        result_valid  <= 1'b1;
                        result        <= '{KIND_POINT, col_reg, row_reg, 17'd0};
                    end
                    else if ({1'b0, col_reg} == eff_w - 9'd1)
                    begin
                        col_reg <= '0;
                        if ({1'b0, row_reg} == eff_h - 9'd1)
                        begin
                            phase_reg    <= 2'd3;
                            state_reg    <= S_IDLE;
                            result_valid <= 1'b1;
                            result       <= '{KIND_DONE, 8'd0, 8'd0, 17'd0};
                        end
                        else
                        begin
                            row_reg <= row_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 8'd1;
                    end
                end
                S_RING_RD:
                begin
                    if (probe_ok)
                    begin
                        row_reg   <= probe_r[7:0];
                        col_reg   <= probe_c[7:0];
                        state_reg <= S_RING_CHK;
                    end
                    else if (ring_reg == RingBits'(RingCount - 1))
                    begin
                        prod_a_reg <= $signed({10'd0, cur_col_reg}) * $signed({10'd0, start_row_reg});
                        prod_b_reg <= $signed({10'd0, start_col_reg}) * $signed({10'd0, cur_row_reg});
                        state_reg  <= S_END_MUL;
                    end
                    else
                    begin
                        ring_reg <= ring_reg + 1'b1;
                    end
                end
                S_RING_CHK:
                begin
                    if (edge_rd == EDGE_FRESH)
                    begin
                        prod_a_reg <= $signed({10'd0, cur_col_reg}) * $signed({10'd0, row_reg});
                        prod_b_reg <= $signed({10'd0, col_reg}) * $signed({10'd0, cur_row_reg});
                        cur_row_reg <= row_reg;
                        cur_col_reg <= col_reg;
                        if (count_reg != CountMax)
                        begin
                            count_reg <= count_reg + 17'd1;
                        end
                        state_reg    <= S_END_FIN;
                        result_valid <= 1'b1;
                        result       <= '{KIND_POINT, col_reg, row_reg, 17'd0};
                    end
                    else if (ring_reg == RingBits'(RingCount - 1))
                    begin
                        prod_a_reg <= $signed({10'd0, cur_col_reg}) * $signed({10'd0, start_row_reg});
                        prod_b_reg <= $signed({10'd0, start_col_reg}) * $signed({10'd0, cur_row_reg});
                        state_reg  <= S_END_MUL;
                    end
                    else
                    begin
                        ring_reg  <= ring_reg + 1'b1;
                        state_reg <= S_RING_RD;
                    end
                end
                S_END_FIN:
                begin
                    area_reg  <= area_sum;
                    state_reg <= S_IDLE;
                end
                S_END_MUL:
                begin
                    area_reg     <= area_abs;
                    phase_reg    <= 2'd1;
                    state_reg    <= S_IDLE;
                    result_valid <= 1'b1;
                    result.kind  <= ((area_abs > $signed({23'd0, min_area_reg, 1'b0}))
                                     && (count_reg > 17'd2) && (dr < 9'd3) && (dc < 9'd3))
                                    ? KIND_ACCEPT : KIND_REJECT;
                    result.x     <= '0;
                    result.y     <= '0;
                    result.point_count <= count_reg;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/rect_edge_mem.sv
module rect_edge_mem (
    input  logic                     clk,
    input  rect_pkg::edge_port_t     port,
    output logic [1:0]               rd_data
);
    import rect_pkg::*;

    logic [1:0] mem [0:(1<<AddrBits)-1];

    always_ff @(posedge clk)
    begin
        if (port.wr_en)
        begin
            mem[port.wr_addr] <= port.wr_data;
        end
        rd_data <= mem[port.rd_addr];
    end
endmodule

### rtl/core/rect_pixel_mem.sv
module rect_pixel_mem (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [rect_pkg::AddrBits-1:0] wr_addr,
    input  logic [31:0]                   wr_data,
    input  logic [rect_pkg::AddrBits-1:0] rd_addr,
    output logic [31:0]                   rd_data
);
    import rect_pkg::*;

    logic [31:0] mem [0:(1<<AddrBits)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
